// ===== src/fqf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqf_pkg
// Shared constants for the quality record filter: byte codes, register
// indexes, reset values and field widths.
// ----------------------------------------------------------------------------
package fqf_pkg;

  localparam int MAX_QUAL_DEFAULT   = 1024;
  localparam int FIFO_DEPTH_DEFAULT = 4;

  localparam int THR_W     = 7;
  localparam int RATIO_W   = 15;
  localparam int OUT_CNT_W = 11;
  localparam int TOTAL_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int BYTE_W    = 8;

  localparam logic [BYTE_W-1:0]    NEWLINE_BYTE = 8'd10;
  localparam logic [BYTE_W:0]      PHRED_OFFSET = 9'd33;
  localparam int                   PERCENT_Q8   = 25600;
  localparam logic [1:0]           LINE_QUALITY = 2'd3;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATIO     = 2'd1;

  localparam logic [THR_W-1:0]     THRESHOLD_RESET = 7'd20;
  localparam logic [RATIO_W-1:0]   RATIO_RESET     = 15'd20480;

endpackage

`default_nettype wire

// ===== src/fqf_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqf_fifo
// Small register queue between the byte front end and the verdict back end.
// ----------------------------------------------------------------------------
module fqf_fifo #(
  parameter int WIDTH = 22,
  parameter int DEPTH = 4
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_valid,
  output logic                  wr_ready,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  rd_valid,
  input  wire logic             rd_ready,
  output logic      [WIDTH-1:0] rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             wr_fire;
  logic             rd_fire;

  assign wr_ready = (count != CNT_FULL);
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rd_ptr];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_fire) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr_fire) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (rd_fire) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (wr_fire && !rd_fire) begin
        count <= count + 1'b1;
      end else if (rd_fire && !wr_fire) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/fqf_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqf_front
// Byte front end: tracks the line phase and counts quality characters,
// pushing one record of counts at the newline that ends a quality line.
// ----------------------------------------------------------------------------
module fqf_front #(
  parameter int MAX_QUAL = fqf_pkg::MAX_QUAL_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              text_valid,
  output logic                                   text_ready,
  input  wire logic [fqf_pkg::BYTE_W-1:0]        text_byte,
  input  wire logic [fqf_pkg::THR_W-1:0]         threshold,
  output logic                                   push_valid,
  input  wire logic                              push_ready,
  output logic [2*$clog2(MAX_QUAL+1)-1:0]        push_data
);
  import fqf_pkg::*;

  localparam int CNT_W = $clog2(MAX_QUAL + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_QUAL);

  logic [1:0]       line_phase;
  logic [CNT_W-1:0] good_count;
  logic [CNT_W-1:0] char_count;
  logic             accept;
  logic             is_newline;
  logic             is_good;
  logic             on_quality;

  assign text_ready = push_ready;
  assign accept     = text_valid && text_ready;
  assign is_newline = (text_byte == NEWLINE_BYTE);
  assign on_quality = (line_phase == LINE_QUALITY);
  assign is_good    = ({1'b0, text_byte} > ({2'b00, threshold} + PHRED_OFFSET));
  assign push_valid = accept && is_newline && on_quality;
  assign push_data  = {good_count, char_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      line_phase <= '0;
      good_count <= '0;
      char_count <= '0;
    end else if (accept) begin
      if (is_newline) begin
        if (on_quality) begin
          line_phase <= '0;
          good_count <= '0;
          char_count <= '0;
        end else begin
          line_phase <= line_phase + 1'b1;
        end
      end else if (on_quality && (char_count < CNT_MAX)) begin
        char_count <= char_count + 1'b1;
        if (is_good) begin
          good_count <= good_count + 1'b1;
        end
      end
    end
  end

  a_counts_bounded: assert property (@(posedge clk) disable iff (rst)
    (char_count <= CNT_MAX) && (good_count <= char_count))
    else $error("quality counts out of bounds");

  a_clear_after_push: assert property (@(posedge clk) disable iff (rst)
    push_valid |=> (line_phase == '0) && (char_count == '0) && (good_count == '0))
    else $error("counts not cleared after record push");

  a_push_only_quality: assert property (@(posedge clk) disable iff (rst)
    (accept && is_newline && !on_quality) |=> (line_phase == $past(line_phase) + 2'd1))
    else $error("line phase did not advance");

endmodule

`default_nettype wire

// ===== src/fqf_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fqf_back
// Verdict back end: multiplies the record counts, compares, updates the
// saturating totals and holds the result in an output register.
// ----------------------------------------------------------------------------
module fqf_back #(
  parameter int MAX_QUAL = fqf_pkg::MAX_QUAL_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              rec_valid,
  output logic                                   rec_ready,
  input  wire logic [2*$clog2(MAX_QUAL+1)-1:0]   rec_data,
  input  wire logic [fqf_pkg::RATIO_W-1:0]       ratio,
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output logic                                   record_passed,
  output logic [fqf_pkg::OUT_CNT_W-1:0]          good_bases,
  output logic [fqf_pkg::OUT_CNT_W-1:0]          quality_length,
  output logic [fqf_pkg::TOTAL_W-1:0]            records_seen,
  output logic [fqf_pkg::TOTAL_W-1:0]            records_kept
);
  import fqf_pkg::*;

  localparam int CNT_W  = $clog2(MAX_QUAL + 1);
  localparam int PROD_W = CNT_W + RATIO_W;
  localparam int PAD_W  = CNT_W + OUT_CNT_W;

  logic              s1_valid;
  logic [PROD_W-1:0] prod_good;
  logic [PROD_W-1:0] prod_ratio;
  logic [CNT_W-1:0]  s1_good;
  logic [CNT_W-1:0]  s1_len;
  logic              s1_adv;
  logic              rec_fire;
  logic              pass;
  logic [PAD_W-1:0]  good_pad;
  logic [PAD_W-1:0]  len_pad;
  logic [TOTAL_W-1:0] seen_next;
  logic [TOTAL_W-1:0] kept_next;

  assign s1_adv    = s1_valid && (!result_valid || result_ready);
  assign rec_ready = !s1_valid || s1_adv;
  assign rec_fire  = rec_valid && rec_ready;
  assign pass      = (s1_len != '0) && (prod_good > prod_ratio);
  assign good_pad  = {{OUT_CNT_W{1'b0}}, s1_good};
  assign len_pad   = {{OUT_CNT_W{1'b0}}, s1_len};
  assign seen_next = (records_seen == '1) ? records_seen : records_seen + 1'b1;
  assign kept_next = (records_kept == '1) ? records_kept : records_kept + 1'b1;

  always_ff @(posedge clk) begin
    if (rec_fire) begin
      s1_good    <= rec_data[2*CNT_W-1:CNT_W];
      s1_len     <= rec_data[CNT_W-1:0];
      prod_good  <= PROD_W'(rec_data[2*CNT_W-1:CNT_W]) * PROD_W'(PERCENT_Q8);
      prod_ratio <= PROD_W'(ratio) * PROD_W'(rec_data[CNT_W-1:0]);
    end
    if (s1_adv) begin
      record_passed  <= pass;
      good_bases     <= good_pad[OUT_CNT_W-1:0];
      quality_length <= len_pad[OUT_CNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      result_valid <= 1'b0;
      records_seen <= '0;
      records_kept <= '0;
    end else begin
      if (rec_fire) begin
        s1_valid <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result_valid <= 1'b1;
        records_seen <= seen_next;
        if (pass) begin
          records_kept <= kept_next;
        end
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  a_kept_le_seen: assert property (@(posedge clk) disable iff (rst)
    records_kept <= records_seen)
    else $error("kept total exceeds seen total");

  a_totals_hold: assert property (@(posedge clk) disable iff (rst)
    !s1_adv |=> $stable(records_seen) && $stable(records_kept))
    else $error("totals changed without a record");

  a_pass_reported: assert property (@(posedge clk) disable iff (rst)
    (s1_adv && pass) |=> record_passed && result_valid)
    else $error("passing verdict not reported");

endmodule

`default_nettype wire

// ===== src/fastq_quality_record_filter.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fastq_quality_record_filter
// FASTQ quality line filter: one verdict and running totals per record.
// ----------------------------------------------------------------------------
// result: the record pushed at the newline that ends a quality line passes
//   queue write, multiply stage and output register; one result per cycle at most
// throughput: one text byte per cycle while the record queue is not full
// reset: line phase, counts, queue and totals clear; score threshold
//   returns to 20 and ratio to 20480; no clearing pass
module fastq_quality_record_filter #(
  parameter int MAX_QUAL   = fqf_pkg::MAX_QUAL_DEFAULT,
  parameter int FIFO_DEPTH = fqf_pkg::FIFO_DEPTH_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [fqf_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [fqf_pkg::RATIO_W-1:0]       cfg_data,
  input  wire logic                              text_valid,
  output logic                                   text_ready,
  input  wire logic [fqf_pkg::BYTE_W-1:0]        text_byte,
  output logic                                   result_valid,
  input  wire logic                              result_ready,
  output logic                                   record_passed,
  output logic [fqf_pkg::OUT_CNT_W-1:0]          good_bases,
  output logic [fqf_pkg::OUT_CNT_W-1:0]          quality_length,
  output logic [fqf_pkg::TOTAL_W-1:0]            records_seen,
  output logic [fqf_pkg::TOTAL_W-1:0]            records_kept
);
  import fqf_pkg::*;

  localparam int CNT_W = $clog2(MAX_QUAL + 1);
  localparam int REC_W = 2 * CNT_W;

  logic [THR_W-1:0]   score_threshold;
  logic [RATIO_W-1:0] ratio_percent_q8;
  logic               push_valid;
  logic               push_ready;
  logic [REC_W-1:0]   push_data;
  logic               rec_valid;
  logic               rec_ready;
  logic [REC_W-1:0]   rec_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      score_threshold  <= THRESHOLD_RESET;
      ratio_percent_q8 <= RATIO_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_THRESHOLD: score_threshold  <= cfg_data[THR_W-1:0];
        CFG_RATIO:     ratio_percent_q8 <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  fqf_front #(
    .MAX_QUAL (MAX_QUAL)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .text_valid (text_valid),
    .text_ready (text_ready),
    .text_byte  (text_byte),
    .threshold  (score_threshold),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  fqf_fifo #(
    .WIDTH (REC_W),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_data  (push_data),
    .rd_valid (rec_valid),
    .rd_ready (rec_ready),
    .rd_data  (rec_data)
  );

  fqf_back #(
    .MAX_QUAL (MAX_QUAL)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .rec_valid      (rec_valid),
    .rec_ready      (rec_ready),
    .rec_data       (rec_data),
    .ratio          (ratio_percent_q8),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .record_passed  (record_passed),
    .good_bases     (good_bases),
    .quality_length (quality_length),
    .records_seen   (records_seen),
    .records_kept   (records_kept)
  );

endmodule

`default_nettype wire

// ===== bench/fastq_quality_record_filter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fastq_quality_record_filter_test
// Streams FASTQ text into the quality record filter: a directed set of
// records (empty, boundary ratio, low bytes, overlong quality line) and then
// random records and noise in several register settings and idling phases.
// Each verdict is predicted from the accepted bytes and checked in order.
// ----------------------------------------------------------------------------
module fastq_quality_record_filter_test;
  import fqf_pkg::*;

  localparam int QUAL_CAP = MAX_QUAL_DEFAULT;
  localparam int PHASE_BYTES = 64;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic                 passed;
    logic [OUT_CNT_W-1:0] good;
    logic [OUT_CNT_W-1:0] length;
    logic [TOTAL_W-1:0]   seen;
    logic [TOTAL_W-1:0]   kept;
  } verdict_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RATIO_W-1:0]   cfg_data = '0;
  logic                 text_valid = 1'b0;
  logic                 text_ready;
  logic [BYTE_W-1:0]    text_byte = '0;
  logic                 result_valid;
  logic                 result_ready = 1'b0;
  logic                 record_passed;
  logic [OUT_CNT_W-1:0] good_bases;
  logic [OUT_CNT_W-1:0] quality_length;
  logic [TOTAL_W-1:0]   records_seen;
  logic [TOTAL_W-1:0]   records_kept;

  fastq_quality_record_filter #(
    .MAX_QUAL(QUAL_CAP)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .text_valid(text_valid),
    .text_ready(text_ready),
    .text_byte(text_byte),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .record_passed(record_passed),
    .good_bases(good_bases),
    .quality_length(quality_length),
    .records_seen(records_seen),
    .records_kept(records_kept)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // text waiting to be sent and verdicts waiting to arrive
  logic [BYTE_W-1:0] text_q[$];
  verdict_t          verdict_q[$];
  int                bytes_loaded = 0;
  int                mismatch_count = 0;
  int                idle_pct = 0;
  int                stall_pct = 0;

  // filter state as predicted
  logic [THR_W-1:0]   thr_reg = THRESHOLD_RESET;
  logic [RATIO_W-1:0] ratio_reg = RATIO_RESET;
  logic [1:0]         line_no = '0;
  int unsigned        good_tally = 0;
  int unsigned        char_tally = 0;
  logic [TOTAL_W-1:0] seen_total = '0;
  logic [TOTAL_W-1:0] kept_total = '0;

  function automatic void judge_byte(input logic [BYTE_W-1:0] b);
    logic     pass;
    verdict_t v;
    if (b != NEWLINE_BYTE) begin
      if (line_no == LINE_QUALITY && char_tally < QUAL_CAP) begin
        char_tally++;
        if (int'(b) > int'(thr_reg) + int'(PHRED_OFFSET)) good_tally++;
      end
    end else if (line_no != LINE_QUALITY) begin
      line_no = line_no + 2'd1;
    end else begin
      pass = (char_tally != 0) &&
             (longint'(good_tally) * PERCENT_Q8 > longint'(ratio_reg) * char_tally);
      if (seen_total != '1) seen_total++;
      if (pass && kept_total != '1) kept_total++;
      v.passed = pass;
      v.good = good_tally[OUT_CNT_W-1:0];
      v.length = char_tally[OUT_CNT_W-1:0];
      v.seen = seen_total;
      v.kept = kept_total;
      verdict_q.push_back(v);
      good_tally = 0;
      char_tally = 0;
      line_no = '0;
    end
  endfunction

  // text driver
  always @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else begin
      if (text_valid && text_ready) judge_byte(text_byte);
      if (!text_valid || text_ready) begin
        if (text_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
          text_valid <= 1'b1;
          text_byte <= text_q.pop_front();
        end else begin
          text_valid <= 1'b0;
        end
      end
    end
  end

  // verdict monitor
  always @(posedge clk) begin : watch
    verdict_t got;
    verdict_t want;
    if (rst) begin
      result_ready <= 1'b0;
    end else begin
      if (result_valid && result_ready) begin
        got = {record_passed, good_bases, quality_length, records_seen, records_kept};
        if (verdict_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected verdict: pass=%0d good=%0d len=%0d seen=%0d kept=%0d",
                     got.passed, got.good, got.length, got.seen, got.kept);
        end else begin
          want = verdict_q.pop_front();
          if (got !== want) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display({"verdict mismatch: expected pass=%0d good=%0d len=%0d ",
                        "seen=%0d kept=%0d, got pass=%0d good=%0d len=%0d ",
                        "seen=%0d kept=%0d"},
                       want.passed, want.good, want.length, want.seen, want.kept,
                       got.passed, got.good, got.length, got.seen, got.kept);
          end
        end
      end
      result_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RATIO_W-1:0] data);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_THRESHOLD) thr_reg = data[THR_W-1:0];
    else if (idx == CFG_RATIO) ratio_reg = data;
  endtask

  task automatic put_byte(input logic [BYTE_W-1:0] b);
    text_q.push_back(b);
    bytes_loaded++;
  endtask

  task automatic put_line(input int len, input int lo, input int hi);
    int b;
    for (int i = 0; i < len; i++) begin
      do b = $urandom_range(hi, lo); while (b == NEWLINE_BYTE);
      put_byte(b[BYTE_W-1:0]);
    end
    put_byte(NEWLINE_BYTE);
  endtask

  task automatic put_quality_text(input string s);
    put_line($urandom_range(5, 1), 33, 126);
    put_line($urandom_range(6), 65, 90);
    put_line($urandom_range(1), 33, 126);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
    put_byte(NEWLINE_BYTE);
  endtask

  function automatic logic [BYTE_W-1:0] pick_quality_byte();
    int v;
    case ($urandom_range(4))
      0: v = $urandom_range(255);
      1, 2: v = int'(thr_reg) + 30 + int'($urandom_range(6));
      default: v = $urandom_range(126, 33);
    endcase
    if (v == NEWLINE_BYTE) v = 11;
    return v[BYTE_W-1:0];
  endfunction

  task automatic put_random_record();
    int n;
    if ($urandom_range(9) == 0) begin
      // broken record: stray bytes and newlines
      n = $urandom_range(12, 1);
      for (int i = 0; i < n; i++)
        put_byte(($urandom_range(2) == 0) ? NEWLINE_BYTE : BYTE_W'($urandom_range(255)));
    end else begin
      put_line($urandom_range(6), 0, 255);
      put_line($urandom_range(8), 33, 126);
      put_line($urandom_range(2), 33, 126);
      n = $urandom_range(24);
      for (int i = 0; i < n; i++) put_byte(pick_quality_byte());
      put_byte(NEWLINE_BYTE);
    end
  endtask

  task automatic settle();
    while (text_q.size() != 0 || text_valid || verdict_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic run_phase(input int idle, input int stall);
    int target;
    idle_pct = idle;
    stall_pct = stall;
    target = bytes_loaded + PHASE_BYTES;
    while (bytes_loaded < target) put_random_record();
    settle();
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset register values: threshold 20, ratio 80 percent
    put_quality_text("");
    put_quality_text("55555");
    put_quality_text("66666");
    put_quality_text("66665");
    put_quality_text("666665");
    put_line(0, 0, 0);
    put_line(0, 0, 0);
    put_line(0, 0, 0);
    put_byte(8'd0);
    put_byte(8'd13);
    put_byte(8'd32);
    put_byte(8'd33);
    put_byte(8'd128);
    put_byte(8'd255);
    put_byte(NEWLINE_BYTE);
    // extreme bytes on the other lines are ignored
    put_byte(8'd255);
    put_byte(8'd0);
    put_byte(NEWLINE_BYTE);
    put_line(3, 128, 255);
    put_line(2, 0, 9);
    put_byte(8'd73);
    put_byte(NEWLINE_BYTE);
    // overlong quality line: good bytes past the cap are not counted
    put_line(2, 33, 126);
    put_line(2, 65, 90);
    put_line(0, 0, 0);
    for (int i = 0; i < QUAL_CAP - 4; i++) put_byte(8'd33);
    for (int i = 0; i < 10; i++) put_byte(8'd126);
    put_byte(NEWLINE_BYTE);
    run_phase(0, 0);

    write_reg(CFG_THRESHOLD, 15'h7F80);
    write_reg(CFG_RATIO, '0);
    write_reg(CFG_SPARE_LO, 15'h7FFF);
    write_reg(CFG_SPARE_HI, RATIO_W'($urandom_range(32767)));
    run_phase(81, 0);

    write_reg(CFG_THRESHOLD, {8'($urandom_range(255)), 7'd93});
    write_reg(CFG_RATIO, 15'(PERCENT_Q8));
    run_phase(0, 81);

    write_reg(CFG_THRESHOLD, 15'h007F);
    write_reg(CFG_RATIO, 15'h7FFF);
    run_phase(31, 31);

    write_reg(CFG_THRESHOLD, RATIO_W'($urandom_range(93)));
    write_reg(CFG_RATIO, RATIO_W'($urandom_range(PERCENT_Q8)));
    run_phase(0, 0);

    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// ===== fastq_quality_record_filter.f =====
src/fqf_pkg.sv
src/fqf_fifo.sv
src/fqf_front.sv
src/fqf_back.sv
src/fastq_quality_record_filter.sv
bench/fastq_quality_record_filter_test.sv
